>>> rtl/core/hsfk_pkg.sv
package hsfk_pkg;

    // fixed skeleton and number formats
    localparam int NODE_COUNT = 20;
    localparam int NODE_W     = 5;
    localparam int POS_WIDTH  = 32;
    localparam int QUAT_WIDTH = 16;
    localparam int QFRAC      = QUAT_WIDTH - 1;

    // datapath widths
    localparam int VEC_W   = POS_WIDTH + 1;
    localparam int MAT_W   = QUAT_WIDTH + 3;
    localparam int PROD_W  = VEC_W + MAT_W;
    localparam int QPROD_W = 2 * QUAT_WIDTH;
    localparam int MSUM_W  = QPROD_W + 3;
    localparam int ACC_W   = PROD_W + 2;

    // command codes
    localparam logic [1:0] CMD_LOAD_REST = 2'd0;
    localparam logic [1:0] CMD_LOAD_QUAT = 2'd1;
    localparam logic [1:0] CMD_COMPUTE   = 2'd2;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

    typedef struct packed {
        logic [1:0]                   cmd;
        logic [NODE_W-1:0]            node;
        logic signed [POS_WIDTH-1:0]  pos_x;
        logic signed [POS_WIDTH-1:0]  pos_y;
        logic signed [POS_WIDTH-1:0]  pos_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]           out_node;
        logic signed [POS_WIDTH-1:0] out_x;
        logic signed [POS_WIDTH-1:0] out_y;
        logic signed [POS_WIDTH-1:0] out_z;
        logic                        last;
    } res_t;

    // chain roots hang from the wrist, others from the node before
    function automatic logic [NODE_W-1:0] parent_of(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] p;
        if (n == 5'd0 || n == 5'd1 || n == 5'd4 || n == 5'd8 || n == 5'd12 || n == 5'd16)
        begin
            p = '0;
        end
        else
        begin
            p = n - 1'b1;
        end
        return p;
    endfunction

    // quaternion product schedule: {left, right} component index (w x y z)
    function automatic logic [3:0] qpair(input logic [3:0] i);
        logic [3:0] r;
        unique case (i)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd1, 2'd1};
            4'd2:    r = {2'd2, 2'd2};
            4'd3:    r = {2'd3, 2'd3};
            4'd4:    r = {2'd1, 2'd2};
            4'd5:    r = {2'd0, 2'd3};
            4'd6:    r = {2'd1, 2'd3};
            4'd7:    r = {2'd0, 2'd2};
            4'd8:    r = {2'd2, 2'd3};
            4'd9:    r = {2'd0, 2'd1};
            default: r = '0;
        endcase
        return r;
    endfunction

    // matrix entry index to row
    function automatic logic [1:0] vrow(input logic [3:0] i);
        logic [1:0] r;
        unique case (i)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // matrix entry index to column
    function automatic logic [1:0] vcol(input logic [3:0] i);
        logic [1:0] r;
        unique case (i)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/hsfk_ram.sv
module hsfk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/hsfk_mul.sv
module hsfk_mul (
    input  logic                                clk,
    input  logic signed [hsfk_pkg::VEC_W-1:0]   op_a,
    input  logic signed [hsfk_pkg::MAT_W-1:0]   op_b,
    output logic signed [hsfk_pkg::PROD_W-1:0]  prod
);
    import hsfk_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // shared signed multiplier with registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/hand_skeleton_forward_kinematics_unit.sv
// Hand skeleton forward kinematics for a 20-node tree (wrist, thumb and four fingers).
// Input channel req/req_valid/req_stall: cmd 0 stores a node's rest position,
// cmd 1 stores a node's quaternion, cmd 2 carries the wrist position and starts
// a compute run. Other commands and out-of-range load nodes are dropped.
// Output channel res/res_valid/res_stall: a compute run gives 20 items, one per
// node in node order, last set on node 19.
// Node 0 is presented in the cycle after the compute item is accepted. Each further
// node goes through three memory reads, ten quaternion products and nine
// matrix-vector products, all through one shared multiplier, then a rounding and
// saturation step.
// req_stall is high from accept of a compute item until its last item is taken.
// While res_stall is high the item is held and the run waits.
// Reset (rst_n low, asynchronous) returns the sequencer to idle; stored rest
// positions and quaternions are undefined until written.
module hand_skeleton_forward_kinematics_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  hsfk_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_stall,
    output hsfk_pkg::res_t  res
);
    import hsfk_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_OUT  = 9'b000000010,
        S_RD1  = 9'b000000100,
        S_RD2  = 9'b000001000,
        S_RD3  = 9'b000010000,
        S_QMUL = 9'b000100000,
        S_MAT  = 9'b001000000,
        S_VMUL = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    localparam logic signed [MSUM_W-1:0] MSUM_HALF = MSUM_W'(2 ** (QFRAC - 1));
    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(2 ** (QFRAC - 1));
    localparam logic signed [ACC_W:0]    POS_MAX   =
        {{(ACC_W - POS_WIDTH + 1){1'b0}}, 1'b0, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W:0]    POS_MIN   =
        {{(ACC_W - POS_WIDTH + 1){1'b1}}, 1'b1, {(POS_WIDTH - 1){1'b0}}};

    state_t state_reg, state_next;
    logic [NODE_W-1:0] node_reg;
    logic [3:0]        cnt_reg;
    logic [NODE_W-1:0] par;
    logic              accept;

    logic signed [QUAT_WIDTH-1:0] quat_reg [4];
    logic signed [POS_WIDTH-1:0]  rest_n_reg [3];
    logic signed [POS_WIDTH-1:0]  posed_p_reg [3];
    logic signed [VEC_W-1:0]      vec_reg [3];
    logic signed [QPROD_W-1:0]    qp_reg [10];
    logic signed [MAT_W-1:0]      m_reg [9];
    logic signed [ACC_W-1:0]      acc_reg [3];
    res_t                         res_reg;

    logic                       rest_we, quat_we, posed_we;
    logic [NODE_W-1:0]          rest_raddr, posed_waddr;
    logic [3*POS_WIDTH-1:0]     rest_rdata, posed_rdata, posed_wdata;
    logic [4*QUAT_WIDTH-1:0]    quat_rdata;

    logic signed [VEC_W-1:0]    op_a;
    logic signed [MAT_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic [3:0]                 pair, prev_cnt, m_idx;
    logic signed [MSUM_W-1:0]   mat_sum [9];
    logic signed [POS_WIDTH-1:0] fin_pos [3];

    assign accept    = req_valid & ~req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;
    assign par       = parent_of(node_reg);

    // node stores
    assign rest_we    = accept && req.cmd == CMD_LOAD_REST && req.node < NODE_W'(NODE_COUNT);
    assign quat_we    = accept && req.cmd == CMD_LOAD_QUAT && req.node < NODE_W'(NODE_COUNT);
    assign rest_raddr = (state_reg == S_RD1) ? node_reg : par;

    hsfk_ram #(.WIDTH(3 * POS_WIDTH), .DEPTH(NODE_COUNT)) u_rest_ram (
        .clk   (clk),
        .we    (rest_we),
        .waddr (req.node),
        .wdata ({req.pos_z, req.pos_y, req.pos_x}),
        .raddr (rest_raddr),
        .rdata (rest_rdata)
    );

    hsfk_ram #(.WIDTH(4 * QUAT_WIDTH), .DEPTH(NODE_COUNT)) u_quat_ram (
        .clk   (clk),
        .we    (quat_we),
        .waddr (req.node),
        .wdata ({req.quat_z, req.quat_y, req.quat_x, req.quat_w}),
        .raddr (par),
        .rdata (quat_rdata)
    );

    // posed store: wrist at start of a run, each node when finished
    assign posed_we    = (accept && req.cmd == CMD_COMPUTE) || (state_reg == S_FIN);
    assign posed_waddr = (state_reg == S_FIN) ? node_reg : '0;
    assign posed_wdata = (state_reg == S_FIN) ? {fin_pos[2], fin_pos[1], fin_pos[0]}
                                              : {req.pos_z, req.pos_y, req.pos_x};

    hsfk_ram #(.WIDTH(3 * POS_WIDTH), .DEPTH(NODE_COUNT)) u_posed_ram (
        .clk   (clk),
        .we    (posed_we),
        .waddr (posed_waddr),
        .wdata (posed_wdata),
        .raddr (par),
        .rdata (posed_rdata)
    );

    // multiplier operand select
    assign pair     = qpair(cnt_reg);
    assign prev_cnt = cnt_reg - 1'b1;
    assign m_idx    = (cnt_reg < 4'd9) ? cnt_reg : 4'd0;
    assign prod_ext = {{2{prod[PROD_W-1]}}, prod};

    always_comb
    begin
        if (state_reg == S_QMUL)
        begin
            op_a = VEC_W'(quat_reg[pair[3:2]]);
            op_b = MAT_W'(quat_reg[pair[1:0]]);
        end
        else
        begin
            op_a = vec_reg[vcol(m_idx)];
            op_b = m_reg[m_idx];
        end
    end

    hsfk_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // rotation matrix from stored quaternion products, Q.2F sums
    always_comb
    begin
        logic signed [MSUM_W-1:0] aa, bb, cc, dd, bc, ad, bd, ac, cd, ab;
        aa = MSUM_W'(qp_reg[0]);
        bb = MSUM_W'(qp_reg[1]);
        cc = MSUM_W'(qp_reg[2]);
        dd = MSUM_W'(qp_reg[3]);
        bc = MSUM_W'(qp_reg[4]);
        ad = MSUM_W'(qp_reg[5]);
        bd = MSUM_W'(qp_reg[6]);
        ac = MSUM_W'(qp_reg[7]);
        cd = MSUM_W'(qp_reg[8]);
        ab = MSUM_W'(qp_reg[9]);
        mat_sum[0] = aa + bb - cc - dd;
        mat_sum[1] = (bc - ad) <<< 1;
        mat_sum[2] = (bd + ac) <<< 1;
        mat_sum[3] = (bc + ad) <<< 1;
        mat_sum[4] = aa - bb + cc - dd;
        mat_sum[5] = (cd - ab) <<< 1;
        mat_sum[6] = (bd - ac) <<< 1;
        mat_sum[7] = (cd + ab) <<< 1;
        mat_sum[8] = aa - bb - cc + dd;
    end

    // round each component and add the parent position with saturation
    always_comb
    begin
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W:0]   s;
        for (int j = 0; j < 3; j++)
        begin
            r = (acc_reg[j] + ACC_HALF) >>> QFRAC;
            s = (ACC_W + 1)'(posed_p_reg[j]) + (ACC_W + 1)'(r);
            if (s > POS_MAX)
            begin
                fin_pos[j] = POS_MAX[POS_WIDTH-1:0];
            end
            else if (s < POS_MIN)
            begin
                fin_pos[j] = POS_MIN[POS_WIDTH-1:0];
            end
            else
            begin
                fin_pos[j] = s[POS_WIDTH-1:0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.cmd == CMD_COMPUTE)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = (node_reg == LAST_NODE) ? S_IDLE : S_RD1;
                end
            end
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_QMUL;
            S_QMUL:
            begin
                if (cnt_reg == 4'd10)
                begin
                    state_next = S_MAT;
                end
            end
            S_MAT:  state_next = S_VMUL;
            S_VMUL:
            begin
                if (cnt_reg == 4'd9)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            node_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                node_reg <= '0;
            end
            else if (state_reg == S_OUT && !res_stall && node_reg != LAST_NODE)
            begin
                node_reg <= node_reg + 1'b1;
            end
            if ((state_reg == S_QMUL && cnt_reg != 4'd10)
                || (state_reg == S_VMUL && cnt_reg != 4'd9))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && req.cmd == CMD_COMPUTE)
        begin
            res_reg.out_node <= '0;
            res_reg.out_x    <= req.pos_x;
            res_reg.out_y    <= req.pos_y;
            res_reg.out_z    <= req.pos_z;
            res_reg.last     <= 1'b0;
        end
        else if (state_reg == S_FIN)
        begin
            res_reg.out_node <= node_reg;
            res_reg.out_x    <= fin_pos[0];
            res_reg.out_y    <= fin_pos[1];
            res_reg.out_z    <= fin_pos[2];
            res_reg.last     <= (node_reg == LAST_NODE);
        end

        if (state_reg == S_RD2)
        begin
            for (int j = 0; j < 4; j++)
            begin
                quat_reg[j] <= quat_rdata[j*QUAT_WIDTH +: QUAT_WIDTH];
            end
            for (int j = 0; j < 3; j++)
            begin
                rest_n_reg[j]  <= rest_rdata[j*POS_WIDTH +: POS_WIDTH];
                posed_p_reg[j] <= posed_rdata[j*POS_WIDTH +: POS_WIDTH];
            end
        end

        // bone vector, exact difference
        if (state_reg == S_RD3)
        begin
            for (int j = 0; j < 3; j++)
            begin
                vec_reg[j] <= VEC_W'(rest_n_reg[j])
                              - VEC_W'($signed(rest_rdata[j*POS_WIDTH +: POS_WIDTH]));
            end
        end

        if (state_reg == S_QMUL && cnt_reg != 4'd0)
        begin
            qp_reg[prev_cnt] <= prod[QPROD_W-1:0];
        end

        if (state_reg == S_MAT)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= MAT_W'((mat_sum[i] + MSUM_HALF) >>> QFRAC);
            end
        end

        // accumulate one row product per cycle
        if (state_reg == S_VMUL && cnt_reg != 4'd0)
        begin
            if (vcol(prev_cnt) == 2'd0)
            begin
                acc_reg[vrow(prev_cnt)] <= prod_ext;
            end
            else
            begin
                acc_reg[vrow(prev_cnt)] <= acc_reg[vrow(prev_cnt)] + prod_ext;
            end
        end
    end

endmodule

>>> tb/tb_hand_skeleton_forward_kinematics_unit.sv
module tb_hand_skeleton_forward_kinematics_unit;
    import hsfk_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    hand_skeleton_forward_kinematics_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always #2 clk = ~clk;

    // pending items, expected node positions
    req_t pending_items[$];
    res_t expected_poses[$];
    int mismatch_count = 0;
    bit quiet_phase = 1'b0;
    bit stim_done = 1'b0;
    bit req_taken = 1'b0;

    // shadow skeleton state
    longint rest_pos[NODE_COUNT][3];
    longint quat[NODE_COUNT][4];
    longint posed[NODE_COUNT][3];

    function automatic int node_parent(int n);
        if (n == 1 || n == 4 || n == 8 || n == 12 || n == 16)
            return 0;
        return (n == 0) ? 0 : n - 1;
    endfunction

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_frac(longint v);
        return floor_shr(v + (longint'(1) << (QFRAC - 1)), QFRAC);
    endfunction

    function automatic longint sat_pos(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (POS_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // predict the pose run for one item
    task automatic pose_skeleton(input req_t it);
        longint a, b, c, d, acc;
        longint m[9];
        longint v[3];
        int p;
        res_t r;
        posed[0][0] = it.pos_x;
        posed[0][1] = it.pos_y;
        posed[0][2] = it.pos_z;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            if (n != 0)
            begin
                p = node_parent(n);
                a = quat[p][0]; b = quat[p][1]; c = quat[p][2]; d = quat[p][3];
                m[0] = round_frac(a*a + b*b - c*c - d*d);
                m[1] = round_frac(2*(b*c - a*d));
                m[2] = round_frac(2*(b*d + a*c));
                m[3] = round_frac(2*(b*c + a*d));
                m[4] = round_frac(a*a - b*b + c*c - d*d);
                m[5] = round_frac(2*(c*d - a*b));
                m[6] = round_frac(2*(b*d - a*c));
                m[7] = round_frac(2*(c*d + a*b));
                m[8] = round_frac(a*a - b*b - c*c + d*d);
                for (int j = 0; j < 3; j++)
                    v[j] = rest_pos[n][j] - rest_pos[p][j];
                for (int j = 0; j < 3; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += m[j*3+k] * v[k];
                    posed[n][j] = sat_pos(posed[p][j] + round_frac(acc));
                end
            end
            r.out_node = NODE_W'(n);
            r.out_x = posed[n][0][POS_WIDTH-1:0];
            r.out_y = posed[n][1][POS_WIDTH-1:0];
            r.out_z = posed[n][2][POS_WIDTH-1:0];
            r.last = (n == NODE_COUNT - 1);
            expected_poses.push_back(r);
        end
    endtask

    // apply one accepted item to the shadow state
    task automatic apply_item(input req_t it);
        if (it.cmd == CMD_LOAD_REST && it.node < NODE_COUNT)
        begin
            rest_pos[it.node][0] = it.pos_x;
            rest_pos[it.node][1] = it.pos_y;
            rest_pos[it.node][2] = it.pos_z;
        end
        else if (it.cmd == CMD_LOAD_QUAT && it.node < NODE_COUNT)
        begin
            quat[it.node][0] = it.quat_w;
            quat[it.node][1] = it.quat_x;
            quat[it.node][2] = it.quat_y;
            quat[it.node][3] = it.quat_z;
        end
        else if (it.cmd == CMD_COMPUTE)
        begin
            pose_skeleton(it);
        end
    endtask

    function automatic logic [31:0] rand_pos(int mode);
        case (mode)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic req_t make_item(logic [1:0] cmd, int node, int pmode);
        req_t it;
        it.cmd = cmd;
        it.node = NODE_W'(node);
        it.pos_x = rand_pos(pmode);
        it.pos_y = rand_pos(pmode);
        it.pos_z = rand_pos(pmode);
        it.quat_w = QUAT_WIDTH'($urandom);
        it.quat_x = QUAT_WIDTH'($urandom);
        it.quat_y = QUAT_WIDTH'($urandom);
        it.quat_z = QUAT_WIDTH'($urandom);
        return it;
    endfunction

    function automatic void queue_item(req_t it);
        pending_items.push_back(it);
    endfunction

    // stimulus
    initial
    begin
        req_t it;
        int pick;
        // directed: extreme rest positions and quaternions
        for (int n = 0; n < NODE_COUNT; n++)
            queue_item(make_item(CMD_LOAD_REST, n, (n % 2 == 0) ? 0 : 1));
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            it = make_item(CMD_LOAD_QUAT, n, 2);
            it.quat_w = (n % 3 == 0) ? 16'sh8000 : 16'sh7fff;
            it.quat_x = (n % 2 == 0) ? 16'sh8000 : 16'sh7fff;
            it.quat_y = (n % 4 == 0) ? 16'sh7fff : 16'sh8000;
            it.quat_z = 16'sh8000;
            queue_item(it);
        end
        // ignored items: out-of-range node, unused command; then two compute runs with any node field
        queue_item(make_item(CMD_LOAD_REST, 31, 2));
        queue_item(make_item(CMD_LOAD_QUAT, 20, 2));
        it = make_item(CMD_NONE, $urandom_range(0, 31), 2);
        queue_item(it);
        queue_item(make_item(CMD_COMPUTE, $urandom_range(0, 31), 0));
        queue_item(make_item(CMD_COMPUTE, $urandom_range(0, 31), 1));
        // random: mostly loads with occasional compute runs
        for (int i = 0; i < 234; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                it = make_item(CMD_LOAD_REST, $urandom_range(0, 19), $urandom_range(0, 3));
            else if (pick < 85)
            begin
                it = make_item(CMD_LOAD_QUAT, $urandom_range(0, 19), 2);
                if ($urandom_range(0, 1))
                begin
                    it.quat_w = 16'((($signed($urandom_range(0, 32767)) - 16384) / 2)
                                    + 16384);
                    it.quat_x = 16'($urandom_range(0, 16383)) - 16'd8192;
                end
            end
            else if (pick < 90)
                it = make_item(($urandom_range(0, 1) ? CMD_NONE : CMD_LOAD_REST),
                               $urandom_range(20, 31), 2);
            else
                it = make_item(CMD_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 3));
            if (it.cmd == CMD_NONE)
                it.node = NODE_W'($urandom);
            queue_item(it);
        end
        queue_item(make_item(CMD_COMPUTE, 0, 3));
        stim_done = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    int req_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (req_valid)
                void'(pending_items.pop_front());
            if (req_gap > 0)
            begin
                req_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 &&
                     !quiet_phase && $urandom_range(0, 9) == 0)
            begin
                req_gap = $urandom_range(0, 12);
                req_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                req_valid <= 1'b1;
                req <= pending_items[0];
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
        quiet_phase <= (pending_items.size() < 30);
    end

    // accept side of the input channel
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            apply_item(req);
    end

    // result stall bursts
    int res_gap = 0;
    always @(negedge clk)
    begin
        if (res_gap > 0)
        begin
            res_gap--;
            res_stall <= 1'b1;
        end
        else if (!quiet_phase && $urandom_range(0, 14) == 0)
        begin
            res_gap = $urandom_range(0, 12);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item node=%0d", res.out_node);
            end
            else
            begin
                e = expected_poses.pop_front();
                if (res !== e)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %0d %h %h %h %b got %0d %h %h %h %b",
                                 e.out_node, e.out_x, e.out_y, e.out_z, e.last,
                                 res.out_node, res.out_x, res.out_y, res.out_z, res.last);
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (rst_n && stim_done);
        wait (pending_items.size() == 0 && !req_valid);
        wait (expected_poses.size() == 0);
        repeat (600) @(posedge clk);
        if (mismatch_count == 0 && expected_poses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
